[rtl/wht_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Walsh-Hadamard transform package
// Shared types and constants for the controller and the datapath.
// ----------------------------------------------------------------------------
package wht_pkg;

   // Index fields in the command struct are sized for the largest supported
   // transform and are narrowed by each module to its own index width.
   localparam int IDX_MAX_W = 10;

   localparam logic [2:0] LOG_SIZE_RESET = 3'd6;

   typedef enum logic [1:0] {
      S_LOAD,
      S_FLUSH,
      S_BFLY,
      S_UNLOAD
   } state_type;

   typedef struct packed {
      logic                 load_we;
      logic [IDX_MAX_W-1:0] load_idx;
      logic                 bf_issue;
      logic [IDX_MAX_W-1:0] bf_a_idx;
      logic [IDX_MAX_W-1:0] bf_b_idx;
      logic                 ul_issue;
      logic [IDX_MAX_W-1:0] ul_idx;
      logic                 ul_last;
   } dp_cmd_type;

   typedef struct packed {
      logic pipe_empty;
      logic advance;
   } dp_status_type;

endpackage
`default_nettype wire

[rtl/wht_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Walsh-Hadamard transform channel interfaces
// Sample request channel and coefficient response channel, valid/ready.
// ----------------------------------------------------------------------------
interface wht_req_if #(
   parameter int SAMPLE_WIDTH = 16
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface wht_rsp_if #(
   parameter int COEFF_WIDTH = 22,
   parameter int INDEX_WIDTH = 6
);
   logic                          valid;
   logic                          ready;
   logic signed [COEFF_WIDTH-1:0] coefficient;
   logic        [INDEX_WIDTH-1:0] coeff_index;
   logic                          last_coeff;

   modport source (output valid, output coefficient, output coeff_index,
                   output last_coeff, input ready);
   modport sink   (input valid, input coefficient, input coeff_index,
                   input last_coeff, output ready);
endinterface
`default_nettype wire

[rtl/walsh_hadamard_transform.sv]
`default_nettype none
// After the last sample of a frame the controller waits for the pipeline to
// drain, runs the butterfly stages, then unloads one coefficient per cycle
// while the receiver is ready. A new frame is taken only after the last
// coefficient of the previous one has been issued. The butterfly stages use
// the single butterfly unit doing one pair per cycle on the banked memories.
// Reset clears the control state and sets the length to 64 points.
// ----------------------------------------------------------------------------
// Walsh-Hadamard transform top level
// Natural-order fast Walsh-Hadamard transform of 1 to 2^MAX_LOG_SIZE points.
// ----------------------------------------------------------------------------
module walsh_hadamard_transform #(
   parameter int MAX_LOG_SIZE = 6,
   parameter int SAMPLE_WIDTH = 16
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        csr_wr_en,
   input  wire  [2:0] csr_wr_data,
   wht_req_if.sink    req,
   wht_rsp_if.source  rsp
);

   wht_pkg::dp_cmd_type    cmd;
   wht_pkg::dp_status_type status;

   wht_ctrl #(
      .MAX_LOG_SIZE (MAX_LOG_SIZE)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .in_valid    (req.valid),
      .in_ready    (req.ready),
      .status      (status),
      .cmd         (cmd)
   );

   wht_datapath #(
      .MAX_LOG_SIZE (MAX_LOG_SIZE),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_datapath (
      .clock  (clock),
      .reset  (reset),
      .sample (req.sample),
      .cmd    (cmd),
      .status (status),
      .rsp    (rsp)
   );

endmodule
`default_nettype wire

[rtl/wht_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Walsh-Hadamard transform controller
// Sequences sample loading, the butterfly stages and coefficient unloading.
// ----------------------------------------------------------------------------
module wht_ctrl #(
   parameter int MAX_LOG_SIZE = 6
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     csr_wr_en,
   input  wire  [2:0]              csr_wr_data,
   input  wire                     in_valid,
   output logic                    in_ready,
   input  wht_pkg::dp_status_type  status,
   output wht_pkg::dp_cmd_type     cmd
);

   localparam int LW    = $clog2(MAX_LOG_SIZE + 1);
   localparam int CNT_W = MAX_LOG_SIZE + 1;

   wht_pkg::state_type state_ff, state_in;
   logic [2:0]              log_ff, log_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [MAX_LOG_SIZE-1:0] bcnt_ff, bcnt_in;
   logic [LW-1:0]           h_ff, h_in;

   logic [LW-1:0]           eff_log;
   logic [CNT_W-1:0]        n_m1;
   logic [MAX_LOG_SIZE-1:0] half_m1;
   logic                    load_done;
   logic                    bf_stage_done;
   logic                    ul_done;
   logic [MAX_LOG_SIZE-1:0] pair_a;
   logic [MAX_LOG_SIZE-1:0] pair_b;

   function automatic logic [MAX_LOG_SIZE-1:0] pair_low(
      input logic [MAX_LOG_SIZE-1:0] b,
      input logic [LW-1:0]           h
   );
      logic [MAX_LOG_SIZE-1:0] r;
      r = '0;
      for (int p = 0; p < MAX_LOG_SIZE; p++) begin
         if (p < int'(h)) begin
            r[p] = b[p];
         end else if (p > int'(h)) begin
            r[p] = b[p-1];
         end
      end
      return r;
   endfunction

   always_comb begin
      eff_log = (int'(log_ff) > MAX_LOG_SIZE) ? LW'(MAX_LOG_SIZE) : LW'(log_ff);
      n_m1    = (CNT_W'(1) << eff_log) - CNT_W'(1);
      half_m1 = MAX_LOG_SIZE'((CNT_W'(1) << eff_log) >> 1) - MAX_LOG_SIZE'(1);
      load_done     = (cnt_ff == n_m1);
      bf_stage_done = (bcnt_ff == half_m1);
      ul_done       = (cnt_ff == n_m1);
      pair_a = pair_low(bcnt_ff, h_ff);
      pair_b = pair_a | (MAX_LOG_SIZE'(1) << h_ff);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         wht_pkg::S_LOAD: begin
            if (in_valid && load_done) begin
               state_in = wht_pkg::S_FLUSH;
            end
         end
         wht_pkg::S_FLUSH: begin
            if (status.pipe_empty) begin
               state_in = (eff_log == '0) ? wht_pkg::S_UNLOAD : wht_pkg::S_BFLY;
            end
         end
         wht_pkg::S_BFLY: begin
            if (bf_stage_done && (h_ff == '0)) begin
               state_in = wht_pkg::S_UNLOAD;
            end
         end
         wht_pkg::S_UNLOAD: begin
            if (status.advance && ul_done) begin
               state_in = wht_pkg::S_LOAD;
            end
         end
         default: begin
            state_in = wht_pkg::S_LOAD;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      in_ready     = 1'b0;
      cmd          = '0;
      cmd.load_idx = wht_pkg::IDX_MAX_W'(cnt_ff[MAX_LOG_SIZE-1:0]);
      cmd.bf_a_idx = wht_pkg::IDX_MAX_W'(pair_a);
      cmd.bf_b_idx = wht_pkg::IDX_MAX_W'(pair_b);
      cmd.ul_idx   = wht_pkg::IDX_MAX_W'(cnt_ff[MAX_LOG_SIZE-1:0]);
      cmd.ul_last  = ul_done;
      case (state_ff)
         wht_pkg::S_LOAD: begin
            in_ready    = 1'b1;
            cmd.load_we = in_valid;
         end
         wht_pkg::S_BFLY: begin
            cmd.bf_issue = 1'b1;
         end
         wht_pkg::S_UNLOAD: begin
            cmd.ul_issue = status.advance;
         end
         default: begin
            in_ready = 1'b0;
         end
      endcase
   end

   // Counters and the length register.
   always_comb begin
      log_in  = log_ff;
      cnt_in  = cnt_ff;
      bcnt_in = bcnt_ff;
      h_in    = h_ff;
      case (state_ff)
         wht_pkg::S_LOAD: begin
            if (in_valid) begin
               cnt_in = load_done ? '0 : cnt_ff + CNT_W'(1);
            end
         end
         wht_pkg::S_FLUSH: begin
            bcnt_in = '0;
            h_in    = eff_log - LW'(1);
            cnt_in  = '0;
         end
         wht_pkg::S_BFLY: begin
            if (bf_stage_done) begin
               bcnt_in = '0;
               h_in    = h_ff - LW'(1);
            end else begin
               bcnt_in = bcnt_ff + MAX_LOG_SIZE'(1);
            end
         end
         wht_pkg::S_UNLOAD: begin
            if (status.advance) begin
               cnt_in = ul_done ? '0 : cnt_ff + CNT_W'(1);
            end
         end
         default: begin
            cnt_in = '0;
         end
      endcase
      if (csr_wr_en) begin
         log_in = csr_wr_data;
         cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wht_pkg::S_LOAD;
         log_ff   <= wht_pkg::LOG_SIZE_RESET;
         cnt_ff   <= '0;
         bcnt_ff  <= '0;
         h_ff     <= '0;
      end else begin
         state_ff <= state_in;
         log_ff   <= log_in;
         cnt_ff   <= cnt_in;
         bcnt_ff  <= bcnt_in;
         h_ff     <= h_in;
      end
   end

endmodule
`default_nettype wire

[rtl/wht_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Walsh-Hadamard transform datapath
// Two parity-banked work memories, one butterfly unit and the output stage.
// ----------------------------------------------------------------------------
module wht_datapath #(
   parameter int MAX_LOG_SIZE = 6,
   parameter int SAMPLE_WIDTH = 16
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire  [SAMPLE_WIDTH-1:0]        sample,
   input  wht_pkg::dp_cmd_type            cmd,
   output wht_pkg::dp_status_type         status,
   wht_rsp_if.source                      rsp
);

   localparam int CW    = SAMPLE_WIDTH + MAX_LOG_SIZE;
   localparam int LA    = (MAX_LOG_SIZE > 1) ? MAX_LOG_SIZE - 1 : 1;
   localparam int DEPTH = 1 << (MAX_LOG_SIZE - 1);

   // An index lives in the bank given by its bit parity, so the two members
   // of every butterfly pair always sit in different banks.
   logic [CW-1:0] mem0 [DEPTH];
   logic [CW-1:0] mem1 [DEPTH];

   logic [MAX_LOG_SIZE-1:0] ld_idx, a_idx, b_idx, ul_idx;
   logic                    ld_bank, a_bank, ul_bank;

   logic [1:0]    we;
   logic [LA-1:0] wa [2];
   logic [CW-1:0] wd [2];
   logic [LA-1:0] ra [2];
   logic          rd_en;

   logic [CW-1:0] rq0_ff, rq1_ff;

   logic          bf_wb_ff, bf_wb_in;
   logic          bf_bank_ff;
   logic [LA-1:0] bf_a_loc_ff, bf_b_loc_ff;

   logic signed [CW-1:0] op_a, op_b, sum, diff;

   logic                    rd_valid_ff, rd_valid_in;
   logic                    rd_bank_ff;
   logic [MAX_LOG_SIZE-1:0] rd_idx_ff;
   logic                    rd_last_ff;

   logic                    out_valid_ff, out_valid_in;
   logic [CW-1:0]           out_coeff_ff;
   logic [MAX_LOG_SIZE-1:0] out_idx_ff;
   logic                    out_last_ff;

   logic advance;

   function automatic logic [LA-1:0] loc(input logic [MAX_LOG_SIZE-1:0] idx);
      return LA'(idx >> 1);
   endfunction

   always_comb begin
      ld_idx  = cmd.load_idx[MAX_LOG_SIZE-1:0];
      a_idx   = cmd.bf_a_idx[MAX_LOG_SIZE-1:0];
      b_idx   = cmd.bf_b_idx[MAX_LOG_SIZE-1:0];
      ul_idx  = cmd.ul_idx[MAX_LOG_SIZE-1:0];
      ld_bank = ^ld_idx;
      a_bank  = ^a_idx;
      ul_bank = ^ul_idx;
   end

   always_comb begin
      op_a = bf_bank_ff ? rq1_ff : rq0_ff;
      op_b = bf_bank_ff ? rq0_ff : rq1_ff;
      sum  = op_a + op_b;
      diff = op_a - op_b;
   end

   always_comb begin
      we    = '0;
      wa[0] = loc(ld_idx);
      wa[1] = loc(ld_idx);
      wd[0] = CW'($signed(sample));
      wd[1] = CW'($signed(sample));
      if (cmd.load_we) begin
         we[ld_bank] = 1'b1;
      end
      if (bf_wb_ff) begin
         we              = 2'b11;
         wa[bf_bank_ff]  = bf_a_loc_ff;
         wd[bf_bank_ff]  = sum;
         wa[!bf_bank_ff] = bf_b_loc_ff;
         wd[!bf_bank_ff] = diff;
      end
   end

   always_comb begin
      ra[0] = loc(ul_idx);
      ra[1] = loc(ul_idx);
      if (cmd.bf_issue) begin
         ra[a_bank]  = loc(a_idx);
         ra[!a_bank] = loc(b_idx);
      end
   end

   assign advance = !out_valid_ff || rsp.ready;
   assign rd_en   = cmd.bf_issue || advance;

   always_ff @(posedge clock) begin
      if (we[0]) begin
         mem0[wa[0]] <= wd[0];
      end
      if (rd_en) begin
         rq0_ff <= (we[0] && (wa[0] == ra[0])) ? wd[0] : mem0[ra[0]];
      end
   end

   always_ff @(posedge clock) begin
      if (we[1]) begin
         mem1[wa[1]] <= wd[1];
      end
      if (rd_en) begin
         rq1_ff <= (we[1] && (wa[1] == ra[1])) ? wd[1] : mem1[ra[1]];
      end
   end

   always_comb begin
      bf_wb_in     = cmd.bf_issue;
      rd_valid_in  = advance ? cmd.ul_issue : rd_valid_ff;
      out_valid_in = advance ? rd_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bf_wb_ff     <= 1'b0;
         rd_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         bf_wb_ff     <= bf_wb_in;
         rd_valid_ff  <= rd_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.bf_issue) begin
         bf_bank_ff  <= a_bank;
         bf_a_loc_ff <= loc(a_idx);
         bf_b_loc_ff <= loc(b_idx);
      end
      if (advance) begin
         rd_bank_ff   <= ul_bank;
         rd_idx_ff    <= ul_idx;
         rd_last_ff   <= cmd.ul_last;
         out_coeff_ff <= rd_bank_ff ? rq1_ff : rq0_ff;
         out_idx_ff   <= rd_idx_ff;
         out_last_ff  <= rd_last_ff;
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.coefficient = out_coeff_ff;
   assign rsp.coeff_index = out_idx_ff;
   assign rsp.last_coeff  = out_last_ff;

   assign status.pipe_empty = !rd_valid_ff && !out_valid_ff;
   assign status.advance    = advance;

endmodule
`default_nettype wire
